// File: rtl/ocp_pkg.sv
// shared constants, types and fixed-point helpers for the oscillation phase unit
`timescale 1ns / 1ps
`default_nettype none
package ocp_pkg;

   // field widths
   localparam int ENERGY_W = 32;
   localparam int COMP_W   = 32;
   localparam int DM_W     = 32;
   localparam int BASE_W   = 24;
   localparam int SCALE_W  = 32;
   localparam int PHASE_W  = 32;

   // number of mass splittings
   localparam int SPLIT_N  = 3;

   // divider shape: dividend is M >> 17, divisor is the energy
   localparam int DIV_NW   = 70;
   localparam int DIV_DW   = 32;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_DM_SQ_12    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DM_SQ_13    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DM_SQ_23    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE_M  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_SCALE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COSINE_MODE = 3'd5;

   // q30 arithmetic
   typedef logic signed [32:0] q30_type;
   localparam q30_type Q30_ONE  = 33'sd1073741824;
   localparam logic [65:0] Q30_HALF = 66'd536870912;

   // odd taylor coefficients of sin(pi/2 x), horner order after the x^11 seed
   localparam int HORNER_N = 5;
   localparam q30_type SC11 = -33'sd3864;
   localparam q30_type HORNER_COEF [HORNER_N] = '{
      33'sd172272, -33'sd5026995, 33'sd85569306, -33'sd693598669, 33'sd1686629713
   };

   // product of two q30 values, rounded half away from zero
   function automatic q30_type q30_mul(input q30_type a, input q30_type b);
      logic signed [65:0] p;
      logic [65:0] m;
      logic [65:0] r;
      q30_type rs;
      p  = 66'(a) * 66'(b);
      m  = p[65] ? 66'(-p) : 66'(p);
      r  = (m + Q30_HALF) >> 30;
      rs = signed'(r[32:0]);
      return p[65] ? -rs : rs;
   endfunction

endpackage
`default_nettype wire

// File: rtl/ocp_div.sv
// pipelined restoring divider, one quotient bit per stage, several lanes sharing a divisor
`timescale 1ns / 1ps
`default_nettype none
module ocp_div #(
   parameter int LANES = ocp_pkg::SPLIT_N,
   parameter int NW    = ocp_pkg::DIV_NW,
   parameter int DW    = ocp_pkg::DIV_DW,
   parameter int TAG_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic [NW-1:0]    n_in  [LANES],
   input  wire logic [DW-1:0]    d_in,
   input  wire logic [TAG_W-1:0] tag_in,
   output logic      [DW-1:0]    q_out [LANES],
   output logic      [TAG_W-1:0] tag_out
);
   import ocp_pkg::*;

   logic [DW-1:0]    rem_ff [NW][LANES];
   logic [DW-1:0]    rem_in [NW][LANES];
   logic [NW-1:0]    num_ff [NW][LANES];
   logic [NW-1:0]    num_in [NW][LANES];
   logic [DW-1:0]    quo_ff [NW][LANES];
   logic [DW-1:0]    quo_in [NW][LANES];
   logic [DW-1:0]    den_ff [NW];
   logic [DW-1:0]    den_in [NW];
   logic [TAG_W-1:0] tag_ff [NW];
   logic [TAG_W-1:0] tag_in_s [NW];

   // one compare and subtract per stage and lane
   always_comb begin
      logic [DW-1:0] rp;
      logic [NW-1:0] np;
      logic [DW-1:0] qp;
      logic [DW-1:0] dp;
      logic [DW:0]   t;
      logic          ge;
      for (int k = 0; k < NW; k++) begin
         dp = (k == 0) ? d_in : den_ff[k-1];
         den_in[k]   = dp;
         tag_in_s[k] = (k == 0) ? tag_in : tag_ff[k-1];
         for (int l = 0; l < LANES; l++) begin
            rp = (k == 0) ? '0 : rem_ff[k-1][l];
            np = (k == 0) ? n_in[l] : num_ff[k-1][l];
            qp = (k == 0) ? '0 : quo_ff[k-1][l];
            t  = {rp, np[NW-1]};
            ge = (t >= {1'b0, dp});
            rem_in[k][l] = ge ? DW'(t - {1'b0, dp}) : t[DW-1:0];
            num_in[k][l] = {np[NW-2:0], 1'b0};
            quo_in[k][l] = {qp[DW-2:0], ge};
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NW; k++) begin
            den_ff[k] <= den_in[k];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               num_ff[k][l] <= num_in[k][l];
               quo_ff[k][l] <= quo_in[k][l];
            end
         end
      end
   end

   // sideband travels with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NW; k++) tag_ff[k] <= '0;
      end else if (en) begin
         for (int k = 0; k < NW; k++) tag_ff[k] <= tag_in_s[k];
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) q_out[l] = quo_ff[NW-1][l];
      tag_out = tag_ff[NW-1];
   end

endmodule
`default_nettype wire

// File: rtl/ocp_sin.sv
// pipelined sine of an angle in turns, horner polynomial with one multiply per stage
`timescale 1ns / 1ps
`default_nettype none
module ocp_sin #(
   parameter int LANES = 2 * ocp_pkg::SPLIT_N,
   parameter int TAG_W = 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic [ocp_pkg::PHASE_W-1:0]  ang_in [LANES],
   input  wire logic [TAG_W-1:0]             tag_in,
   output ocp_pkg::q30_type                  sin_out [LANES],
   output logic      [TAG_W-1:0]             tag_out
);
   import ocp_pkg::*;

   q30_type    xa_ff  [LANES];
   logic       nga_ff [LANES];
   q30_type    xb_ff  [LANES];
   q30_type    x2b_ff [LANES];
   logic       ngb_ff [LANES];
   q30_type    th_ff  [HORNER_N][LANES];
   q30_type    th_in  [HORNER_N][LANES];
   q30_type    xh_ff  [HORNER_N][LANES];
   q30_type    x2h_ff [HORNER_N][LANES];
   logic       ngh_ff [HORNER_N][LANES];
   q30_type    ss_ff  [LANES];
   logic       ngs_ff [LANES];
   q30_type    y_ff   [LANES];
   logic [TAG_W-1:0] tag_ff [HORNER_N+4];

   // horner steps
   always_comb begin
      for (int j = 0; j < HORNER_N; j++) begin
         for (int l = 0; l < LANES; l++) begin
            if (j == 0) begin
               th_in[j][l] = HORNER_COEF[j] + q30_mul(x2b_ff[l], SC11);
            end else begin
               th_in[j][l] = HORNER_COEF[j] + q30_mul(x2h_ff[j-1][l], th_ff[j-1][l]);
            end
         end
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            // quadrant fold
            xa_ff[l]  <= ang_in[l][30] ? (Q30_ONE - q30_type'({3'b000, ang_in[l][29:0]}))
                                       : q30_type'({3'b000, ang_in[l][29:0]});
            nga_ff[l] <= ang_in[l][31];
            // square
            xb_ff[l]  <= xa_ff[l];
            x2b_ff[l] <= q30_mul(xa_ff[l], xa_ff[l]);
            ngb_ff[l] <= nga_ff[l];
            for (int j = 0; j < HORNER_N; j++) begin
               th_ff[j][l]  <= th_in[j][l];
               xh_ff[j][l]  <= (j == 0) ? xb_ff[l]  : xh_ff[j-1][l];
               x2h_ff[j][l] <= (j == 0) ? x2b_ff[l] : x2h_ff[j-1][l];
               ngh_ff[j][l] <= (j == 0) ? ngb_ff[l] : ngh_ff[j-1][l];
            end
            // final multiply by x
            ss_ff[l]  <= q30_mul(xh_ff[HORNER_N-1][l], th_ff[HORNER_N-1][l]);
            ngs_ff[l] <= ngh_ff[HORNER_N-1][l];
            // clamp and sign
            if (ss_ff[l] < 0) begin
               y_ff[l] <= '0;
            end else if (ss_ff[l] > Q30_ONE) begin
               y_ff[l] <= ngs_ff[l] ? -Q30_ONE : Q30_ONE;
            end else begin
               y_ff[l] <= ngs_ff[l] ? -ss_ff[l] : ss_ff[l];
            end
         end
      end
   end

   // sideband line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HORNER_N + 4; k++) tag_ff[k] <= '0;
      end else if (en) begin
         tag_ff[0] <= tag_in;
         for (int k = 1; k < HORNER_N + 4; k++) tag_ff[k] <= tag_ff[k-1];
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) sin_out[l] = y_ff[l];
      tag_out = tag_ff[HORNER_N+3];
   end

endmodule
`default_nettype wire

// File: rtl/oscillation_phase_components_unit.sv
// top level: oscillation phase components, phase divide and sine pipelines
// throughput: one request per cycle while the result is not stalled,
// set by the 70 stage divider and 9 stage sine pipes
// a stalled result freezes the whole pipeline; requests are taken again when it moves
// reset: synchronous, clears all valid bits and the configuration registers to zero
`timescale 1ns / 1ps
`default_nettype none
module oscillation_phase_components_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ocp_pkg::ENERGY_W-1:0]      req_energy,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [ocp_pkg::COMP_W-1:0]      rsp_comp_12,
   output logic signed [ocp_pkg::COMP_W-1:0]      rsp_comp_13,
   output logic signed [ocp_pkg::COMP_W-1:0]      rsp_comp_23,
   output logic signed [ocp_pkg::COMP_W-1:0]      rsp_comp_cp,
   output logic                                   rsp_zero_energy,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ocp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ocp_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ocp_pkg::*;

   localparam int DIV_TAG_W = 2 + SPLIT_N;
   localparam int SIN_TAG_W = 2;
   localparam int SIN_LANES = 2 * SPLIT_N;

   // configuration registers
   logic [DM_W-1:0]    dm_ff [SPLIT_N];
   logic [BASE_W-1:0]  base_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic               cos_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SPLIT_N; i++) dm_ff[i] <= '0;
         base_ff  <= '0;
         scale_ff <= '0;
         cos_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DM_SQ_12:    dm_ff[0] <= csr_data[DM_W-1:0];
            CSR_DM_SQ_13:    dm_ff[1] <= csr_data[DM_W-1:0];
            CSR_DM_SQ_23:    dm_ff[2] <= csr_data[DM_W-1:0];
            CSR_BASELINE_M:  base_ff  <= csr_data[BASE_W-1:0];
            CSR_PHASE_SCALE: scale_ff <= csr_data[SCALE_W-1:0];
            CSR_COSINE_MODE: cos_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pipeline advance: whole pipe moves unless a result is held
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = rsp_valid_ff;

   // stage 0: capture request
   logic                vld0_ff;
   logic [ENERGY_W-1:0] e0_ff;
   // stage 1: magnitude times scale
   logic                vld1_ff;
   logic [ENERGY_W-1:0] e1_ff;
   logic [63:0]         p1_ff  [SPLIT_N];
   logic                ng1_ff [SPLIT_N];
   // stage 2: partial products with baseline
   logic                vld2_ff;
   logic [ENERGY_W-1:0] e2_ff;
   logic [55:0]         al2_ff [SPLIT_N];
   logic [55:0]         bl2_ff [SPLIT_N];
   logic                ng2_ff [SPLIT_N];
   // stage 3: dividend
   logic                vld3_ff;
   logic [ENERGY_W-1:0] e3_ff;
   logic [DIV_NW-1:0]   n3_ff  [SPLIT_N];
   logic                ng3_ff [SPLIT_N];

   logic [DM_W-1:0] mag_in [SPLIT_N];
   logic [87:0]     m_in   [SPLIT_N];

   always_comb begin
      for (int i = 0; i < SPLIT_N; i++) begin
         mag_in[i] = dm_ff[i][DM_W-1] ? (DM_W'(0) - dm_ff[i]) : dm_ff[i];
         m_in[i]   = 88'(al2_ff[i]) + (88'(bl2_ff[i]) << 32);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= req_valid;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ff <= req_energy;
         e1_ff <= e0_ff;
         e2_ff <= e1_ff;
         e3_ff <= e2_ff;
         for (int i = 0; i < SPLIT_N; i++) begin
            p1_ff[i]  <= 64'(mag_in[i]) * 64'(scale_ff);
            ng1_ff[i] <= dm_ff[i][DM_W-1];
            al2_ff[i] <= 56'(p1_ff[i][31:0]) * 56'(base_ff);
            bl2_ff[i] <= 56'(p1_ff[i][63:32]) * 56'(base_ff);
            ng2_ff[i] <= ng1_ff[i];
            n3_ff[i]  <= m_in[i][86:17];
            ng3_ff[i] <= ng2_ff[i];
         end
      end
   end

   // phase quotient
   logic [DIV_NW-1:0]    div_n   [SPLIT_N];
   logic [DIV_DW-1:0]    div_q   [SPLIT_N];
   logic [DIV_TAG_W-1:0] div_tag_in;
   logic [DIV_TAG_W-1:0] div_tag_out;

   always_comb begin
      for (int i = 0; i < SPLIT_N; i++) div_n[i] = n3_ff[i];
      div_tag_in = {vld3_ff, (e3_ff == '0), ng3_ff[2], ng3_ff[1], ng3_ff[0]};
   end

   ocp_div #(
      .LANES (SPLIT_N),
      .NW    (DIV_NW),
      .DW    (DIV_DW),
      .TAG_W (DIV_TAG_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .n_in    (div_n),
      .d_in    (e3_ff),
      .tag_in  (div_tag_in),
      .q_out   (div_q),
      .tag_out (div_tag_out)
   );

   // signed phase
   logic [PHASE_W-1:0] ph_ff [SPLIT_N];
   logic               vldp_ff;
   logic               zp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vldp_ff <= 1'b0;
      end else if (en) begin
         vldp_ff <= div_tag_out[DIV_TAG_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zp_ff <= div_tag_out[DIV_TAG_W-2];
         for (int i = 0; i < SPLIT_N; i++) begin
            ph_ff[i] <= div_tag_out[i] ? (PHASE_W'(0) - div_q[i]) : div_q[i];
         end
      end
   end

   // sines of the phase and of the doubled phase plus a quarter turn
   logic [PHASE_W-1:0]   sin_ang [SIN_LANES];
   q30_type              sin_val [SIN_LANES];
   logic [SIN_TAG_W-1:0] sin_tag_out;

   always_comb begin
      for (int i = 0; i < SPLIT_N; i++) begin
         sin_ang[i]           = ph_ff[i];
         sin_ang[i + SPLIT_N] = {ph_ff[i][PHASE_W-2:0], 1'b0} + 32'h4000_0000;
      end
   end

   ocp_sin #(
      .LANES (SIN_LANES),
      .TAG_W (SIN_TAG_W)
   ) u_sin (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ang_in  (sin_ang),
      .tag_in  ({vldp_ff, zp_ff}),
      .sin_out (sin_val),
      .tag_out (sin_tag_out)
   );

   // components and first cp product
   q30_type comp_ff [SPLIT_N];
   q30_type c1_ff;
   q30_type s23_ff;
   logic    vldc_ff;
   logic    zc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vldc_ff <= 1'b0;
      end else if (en) begin
         vldc_ff <= sin_tag_out[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zc_ff  <= sin_tag_out[0];
         for (int i = 0; i < SPLIT_N; i++) begin
            comp_ff[i] <= cos_ff ? sin_val[i + SPLIT_N] : q30_mul(sin_val[i], sin_val[i]);
         end
         c1_ff  <= q30_mul(sin_val[0], sin_val[1]);
         s23_ff <= sin_val[2];
      end
   end

   // result register with zero energy forcing
   q30_type cp_out;
   assign cp_out = q30_mul(c1_ff, s23_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vldc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_zero_energy <= zc_ff;
         rsp_comp_12     <= zc_ff ? '0 : comp_ff[0][COMP_W-1:0];
         rsp_comp_13     <= zc_ff ? '0 : comp_ff[1][COMP_W-1:0];
         rsp_comp_23     <= zc_ff ? '0 : comp_ff[2][COMP_W-1:0];
         rsp_comp_cp     <= zc_ff ? '0 : cp_out[COMP_W-1:0];
      end
   end

endmodule
`default_nettype wire
